[sv/czi_pkg.sv]
// Shared types and constants for the crop and 2x zoom block.
package czi_pkg;

    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 4096;
    localparam int QUEUE_DEPTH  = 4;

    localparam int PIX_W     = 8;
    localparam int ROW_W     = 13;
    localparam int COL_W     = 11;
    localparam int IMG_COL_W = 11;
    localparam int WIN_ROW_W = 12;
    localparam int WIN_COL_W = 10;
    localparam int CFG_W     = 12;
    localparam int CFG_ADR_W = 3;

    localparam logic [CFG_ADR_W-1:0] CFG_IMAGE_COLUMNS    = 3'd0;
    localparam logic [CFG_ADR_W-1:0] CFG_WINDOW_FIRST_ROW = 3'd1;
    localparam logic [CFG_ADR_W-1:0] CFG_WINDOW_FIRST_COL = 3'd2;
    localparam logic [CFG_ADR_W-1:0] CFG_WINDOW_LAST_ROW  = 3'd3;
    localparam logic [CFG_ADR_W-1:0] CFG_WINDOW_LAST_COL  = 3'd4;

    localparam logic [IMG_COL_W-1:0] IMAGE_COLUMNS_RESET = 11'd1024;

    typedef struct packed {
        logic [IMG_COL_W-1:0] image_columns;
        logic [WIN_ROW_W-1:0] first_row;
        logic [WIN_COL_W-1:0] first_col;
        logic [WIN_ROW_W-1:0] last_row;
        logic [WIN_COL_W-1:0] last_col;
    } t_cfg;

    // One classified window pixel as queued between front and back.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] mid;
        logic             has_up;
        logic             has_left;
    } t_item;

endpackage

[sv/czi_front.sv]
// Front end: source position counters, crop window test and request classification.
module czi_front #(
    parameter int MAX_COLS = czi_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = czi_pkg::DEF_MAX_ROWS,
    parameter int IDX_W    = $clog2(MAX_COLS)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  czi_pkg::t_cfg             i_cfg,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [czi_pkg::PIX_W-1:0] i_pixel,
    input  logic                      i_queue_full,
    output logic                      o_push,
    output czi_pkg::t_item            o_item,
    output logic [IDX_W-1:0]          o_idx
);
    import czi_pkg::*;

    localparam int CW   = IDX_W;
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CMPW = (CW + 1 > IMG_COL_W) ? CW + 1 : IMG_COL_W;
    localparam int CCW  = (CW > WIN_COL_W) ? CW : WIN_COL_W;
    localparam int RCW  = (RW > WIN_ROW_W) ? RW : WIN_ROW_W;

    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic [PIX_W-1:0] r_left;

    logic          accept;
    logic          in_win;
    logic [CW:0]   col_inc;
    logic [RW:0]   row_inc;
    logic [CW-1:0] wc;
    logic [RW-1:0] wr;
    logic [PIX_W:0] mid_sum;

    assign o_s_tready = !i_queue_full;
    assign accept     = i_s_tvalid && o_s_tready;

    assign in_win = (RCW'(r_row) >= RCW'(i_cfg.first_row)) &&
                    (RCW'(r_row) <= RCW'(i_cfg.last_row)) &&
                    (CCW'(r_col) >= CCW'(i_cfg.first_col)) &&
                    (CCW'(r_col) <= CCW'(i_cfg.last_col));

    assign wr      = RW'(RCW'(r_row) - RCW'(i_cfg.first_row));
    assign wc      = CW'(CCW'(r_col) - CCW'(i_cfg.first_col));
    assign mid_sum = {1'b0, r_left} + {1'b0, i_pixel};

    always_comb begin
        o_item.row      = ROW_W'({wr, 1'b0});
        o_item.col      = COL_W'({wc, 1'b0});
        o_item.pixel    = i_pixel;
        o_item.mid      = mid_sum[PIX_W:1];
        o_item.has_up   = (wr != '0);
        o_item.has_left = (wc != '0);
    end

    assign o_idx  = wc;
    assign o_push = accept && in_win;

    assign col_inc = {1'b0, r_col} + (CW+1)'(1);
    assign row_inc = {1'b0, r_row} + (RW+1)'(1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            // wrap at the image width or at the line store limit
            if ((CMPW'(col_inc) >= CMPW'(i_cfg.image_columns)) ||
                (col_inc >= (CW+1)'(MAX_COLS))) begin
                n_col = '0;
                n_row = (row_inc >= (RW+1)'(MAX_ROWS)) ? '0 : row_inc[RW-1:0];
            end else begin
                n_col = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (accept) begin
                r_left <= i_pixel;
            end
        end
    end

endmodule

[sv/czi_queue.sv]
// Short request queue between front end and back end.
module czi_queue #(
    parameter int IDX_W = 10,
    parameter int DEPTH = czi_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  czi_pkg::t_item i_item,
    input  logic [IDX_W-1:0] i_idx,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output czi_pkg::t_item o_item,
    output logic [IDX_W-1:0] o_idx
);
    import czi_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_items [DEPTH];
    logic [IDX_W-1:0] r_idxs  [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_items[r_rd_ptr];
    assign o_idx   = r_idxs[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_items[r_wr_ptr] <= i_item;
            r_idxs[r_wr_ptr]  <= i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[sv/czi_back.sv]
// Back end: line store banks, result sequencing and the output register.
module czi_back #(
    parameter int MAX_COLS = czi_pkg::DEF_MAX_COLS,
    parameter int IDX_W    = $clog2(MAX_COLS)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    output logic                      o_q_pop,
    input  czi_pkg::t_item            i_q_item,
    input  logic [IDX_W-1:0]          i_q_idx,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [czi_pkg::ROW_W-1:0] o_row,
    output logic [czi_pkg::COL_W-1:0] o_col,
    output logic [czi_pkg::PIX_W-1:0] o_pixel,
    output logic                      o_last
);
    import czi_pkg::*;

    // even zoomed columns in one bank, odd ones in the other
    logic [PIX_W-1:0] r_even_mem [MAX_COLS];
    logic [PIX_W-1:0] r_odd_mem  [MAX_COLS];
    logic [PIX_W-1:0] r_rd_even, r_rd_odd;

    t_item      r_item;
    logic       r_busy;
    logic [3:0] r_mask, n_mask;

    logic             r_out_valid;
    logic [ROW_W-1:0] r_out_row;
    logic [COL_W-1:0] r_out_col;
    logic [PIX_W-1:0] r_out_pixel;
    logic             r_out_last;

    logic             load_ok, emit, pop;
    logic [3:0]       sel;
    logic [ROW_W-1:0] res_row;
    logic [COL_W-1:0] res_col;
    logic [PIX_W-1:0] res_pixel;
    logic [PIX_W:0]   sum_diag, sum_up;
    logic [3:0]       pop_mask;

    assign load_ok = !r_out_valid || i_m_tready;
    assign emit    = r_busy && load_ok;
    assign sel     = r_mask & (~r_mask + 4'd1);
    assign n_mask  = r_mask & ~sel;
    assign pop     = i_q_valid && (!r_busy || (emit && n_mask == 4'd0));
    assign o_q_pop = pop;

    assign pop_mask = {1'b1, i_q_item.has_left,
                       i_q_item.has_up,
                       i_q_item.has_up && i_q_item.has_left};

    assign sum_diag = {1'b0, r_rd_odd} + {1'b0, r_item.mid};
    assign sum_up   = {1'b0, r_rd_even} + {1'b0, r_item.pixel};

    always_comb begin
        res_row   = r_item.row;
        res_col   = r_item.col;
        res_pixel = r_item.pixel;
        unique case (1'b1)
            sel[0]: begin
                res_row   = r_item.row - ROW_W'(1);
                res_col   = r_item.col - COL_W'(1);
                res_pixel = sum_diag[PIX_W:1];
            end
            sel[1]: begin
                res_row   = r_item.row - ROW_W'(1);
                res_pixel = sum_up[PIX_W:1];
            end
            sel[2]: begin
                res_col   = r_item.col - COL_W'(1);
                res_pixel = r_item.mid;
            end
            default: begin
                res_pixel = r_item.pixel;
            end
        endcase
    end

    // read-first: the request sees the row above, then overwrites it
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rd_even <= r_even_mem[i_q_idx];
            r_rd_odd  <= r_odd_mem[i_q_idx - IDX_W'(1)];
            r_even_mem[i_q_idx] <= i_q_item.pixel;
            if (i_q_item.has_left) begin
                r_odd_mem[i_q_idx - IDX_W'(1)] <= i_q_item.mid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_item <= i_q_item;
        end
        if (emit) begin
            r_out_row   <= res_row;
            r_out_col   <= res_col;
            r_out_pixel <= res_pixel;
            r_out_last  <= sel[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_busy <= 1'b1;
                r_mask <= pop_mask;
            end else if (emit) begin
                r_mask <= n_mask;
                if (n_mask == 4'd0) begin
                    r_busy <= 1'b0;
                end
            end
            if (load_ok) begin
                r_out_valid <= emit;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_row      = r_out_row;
    assign o_col      = r_out_col;
    assign o_pixel    = r_out_pixel;
    assign o_last     = r_out_last;

    a_busy_has_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_mask[3])
        else $error("busy request lost its final result");

    a_top_row_no_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_item.has_up) |-> (r_mask[1:0] == 2'b00))
        else $error("odd-row result pending on first window row");

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_busy && r_mask != 4'd0))
        else $error("popped request not held");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && sel[3]) |-> (n_mask == 4'd0))
        else $error("final result sent with results still pending");

endmodule

[sv/crop_zoom2x_interpolate.sv]
// Top level of the crop window and 2x bilinear zoom block.
//
//  channel  dir  handshake              payload (low bit first)
//  s        in   i_s_tvalid/o_s_tready  i_s_tdata: pixel_in[7:0]
//  m        out  o_m_tvalid/i_m_tready  o_m_tdata: out_row[12:0] out_col[23:13]
//                                       pixel_out[31:24]; o_m_tlast: run_last
//  cfg      in   i_cfg_we               i_cfg_addr register index, i_cfg_wdata value
//
// A window pixel causes 1, 2 or 4 results, sent over the single result channel
// one result per cycle while the receiver is ready; a pixel outside the window
// causes none. Results pass the queue, then the back end and output registers.
// Synchronous active-low reset clears counters, queue and handshake state; the
// line store is not cleared. A four-entry queue lets input and output stall apart.
module crop_zoom2x_interpolate #(
    parameter int MAX_COLS = czi_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = czi_pkg::DEF_MAX_ROWS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,    // pixel_in
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [31:0]                   o_m_tdata,    // out_row, out_col, pixel_out
    output logic                          o_m_tlast,    // run_last
    input  logic                          i_cfg_we,
    input  logic [czi_pkg::CFG_ADR_W-1:0] i_cfg_addr,
    input  logic [czi_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import czi_pkg::*;

    localparam int IDX_W = $clog2(MAX_COLS);

    t_cfg r_cfg;

    logic             front_push;
    t_item            front_item;
    logic [IDX_W-1:0] front_idx;
    logic             q_full, q_valid, q_pop;
    t_item            q_item;
    logic [IDX_W-1:0] q_idx;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic [PIX_W-1:0] out_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_columns <= IMAGE_COLUMNS_RESET;
            r_cfg.first_row     <= '0;
            r_cfg.first_col     <= '0;
            r_cfg.last_row      <= '0;
            r_cfg.last_col      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_IMAGE_COLUMNS:    r_cfg.image_columns <= i_cfg_wdata[IMG_COL_W-1:0];
                CFG_WINDOW_FIRST_ROW: r_cfg.first_row     <= i_cfg_wdata[WIN_ROW_W-1:0];
                CFG_WINDOW_FIRST_COL: r_cfg.first_col     <= i_cfg_wdata[WIN_COL_W-1:0];
                CFG_WINDOW_LAST_ROW:  r_cfg.last_row      <= i_cfg_wdata[WIN_ROW_W-1:0];
                CFG_WINDOW_LAST_COL:  r_cfg.last_col      <= i_cfg_wdata[WIN_COL_W-1:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    czi_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .IDX_W    (IDX_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_pixel      (i_s_tdata),
        .i_queue_full (q_full),
        .o_push       (front_push),
        .o_item       (front_item),
        .o_idx        (front_idx)
    );

    czi_queue #(
        .IDX_W (IDX_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .i_idx   (front_idx),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_idx   (q_idx)
    );

    czi_back #(
        .MAX_COLS (MAX_COLS),
        .IDX_W    (IDX_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .o_q_pop    (q_pop),
        .i_q_item   (q_item),
        .i_q_idx    (q_idx),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_row      (out_row),
        .o_col      (out_col),
        .o_pixel    (out_pixel),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {out_pixel, out_col, out_row};

endmodule

[bench/crop_zoom2x_interpolate_test.sv]
// Self-checking bench for crop_zoom2x_interpolate: predicts every zoomed pixel.
module crop_zoom2x_interpolate_test;
    import czi_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int STALL_LIMIT    = 3000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int HOLDOFF_AFTER  = 30;
    localparam int INPUT_ITEMS    = 350;
    localparam int LINE_DEPTH     = 2 * DEF_MAX_COLS;

    localparam logic [CFG_ADR_W-1:0] CFG_SPARE = 3'd7;

    typedef enum logic [1:0] {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL_RATE} pace_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pixel;
        logic             last;
    } zoom_px_t;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata   = '0;     // pixel_in
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [31:0]          o_m_tdata;            // out_row, out_col, pixel_out
    logic                 o_m_tlast;            // run_last
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_ADR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    // Shadow of the block's registers and state
    logic [IMG_COL_W-1:0] cfg_columns   = IMAGE_COLUMNS_RESET;
    logic [WIN_ROW_W-1:0] cfg_first_row = '0;
    logic [WIN_ROW_W-1:0] cfg_last_row  = '0;
    logic [WIN_COL_W-1:0] cfg_first_col = '0;
    logic [WIN_COL_W-1:0] cfg_last_col  = '0;
    int unsigned          src_row = 0;
    int unsigned          src_col = 0;
    logic [PIX_W-1:0]     left_pix = '0;
    logic [PIX_W-1:0]     even_line [LINE_DEPTH];

    zoom_px_t         zoom_expected [$];
    logic [PIX_W-1:0] pixel_queue [$];
    int unsigned      pixels_sent  = 0;
    int unsigned      pixels_taken = 0;
    int unsigned      window_taken = 0;
    int unsigned      mismatches   = 0;
    int unsigned      quiet_cycles = 0;
    int unsigned      holdoff_left = 0;
    logic             holdoff_done = 1'b0;
    pace_t            pace = PACE_SLOW_SINK;

    crop_zoom2x_interpolate dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic [PIX_W-1:0] floor_avg(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PIX_W:1];
    endfunction

    // Work out the zoomed pixels one source pixel causes and advance the counters.
    task automatic zoom_pixel(input logic [PIX_W-1:0] p);
        int unsigned      wr;
        int unsigned      wc;
        logic [ROW_W-1:0] orow;
        logic [COL_W-1:0] ocol;
        logic [COL_W-1:0] ocol_left;
        logic [PIX_W-1:0] mid;
        zoom_px_t         burst [$];
        if (src_row >= cfg_first_row && src_row <= cfg_last_row &&
            src_col >= cfg_first_col && src_col <= cfg_last_col) begin
            wr        = src_row - cfg_first_row;
            wc        = src_col - cfg_first_col;
            orow      = ROW_W'(2 * wr);
            ocol      = COL_W'(2 * wc);
            ocol_left = ocol - 1'b1;
            mid       = floor_avg(left_pix, p);
            // read the line store before this row overwrites it
            if (wc > 0 && wr > 0)
                burst.push_back('{orow - 1'b1, ocol_left,
                                  floor_avg(even_line[ocol_left], mid), 1'b0});
            if (wr > 0)
                burst.push_back('{orow - 1'b1, ocol, floor_avg(even_line[ocol], p), 1'b0});
            if (wc > 0) begin
                burst.push_back('{orow, ocol_left, mid, 1'b0});
                even_line[ocol_left] = mid;
            end
            burst.push_back('{orow, ocol, p, 1'b0});
            even_line[ocol] = p;
            foreach (burst[i]) begin
                burst[i].last = (i == burst.size() - 1);
                zoom_expected.push_back(burst[i]);
            end
            window_taken <= window_taken + 1;
        end
        left_pix = p;
        if (src_col + 1 >= cfg_columns || src_col + 1 >= DEF_MAX_COLS) begin
            src_col = 0;
            src_row = (src_row + 1 >= DEF_MAX_ROWS) ? 0 : src_row + 1;
        end else begin
            src_col = src_col + 1;
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    // Driver: present the next pending pixel once the current one is taken.
    always @(posedge i_clk) begin
        int unsigned idle_pct;
        case (pace)
            PACE_SLOW_SINK:   idle_pct = 16;
            PACE_SLOW_SOURCE: idle_pct = 69;
            default:          idle_pct = 0;
        endcase
        if (!i_s_tvalid || o_s_tready) begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= pixel_queue.pop_front();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random ready, plus one long hold-off to back the block up.
    always @(posedge i_clk) begin
        int unsigned idle_pct;
        case (pace)
            PACE_SLOW_SINK:   idle_pct = 69;
            PACE_SLOW_SOURCE: idle_pct = 16;
            default:          idle_pct = 0;
        endcase
        if (holdoff_left != 0) begin
            i_m_tready   <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (!holdoff_done && window_taken >= HOLDOFF_AFTER) begin
            holdoff_done <= 1'b1;
            holdoff_left <= HOLDOFF_CYCLES;
            i_m_tready   <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Monitor: predict on each accepted request, check each accepted result.
    always @(posedge i_clk) begin
        zoom_px_t want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                zoom_pixel(i_s_tdata);
                pixels_taken <= pixels_taken + 1;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (zoom_expected.size() == 0) begin
                    report_mismatch("result with nothing expected", 0, o_m_tdata);
                end else begin
                    want = zoom_expected.pop_front();
                    if (o_m_tdata[ROW_W-1:0] != want.row)
                        report_mismatch("out_row", want.row, o_m_tdata[ROW_W-1:0]);
                    if (o_m_tdata[ROW_W+COL_W-1:ROW_W] != want.col)
                        report_mismatch("out_col", want.col, o_m_tdata[ROW_W+COL_W-1:ROW_W]);
                    if (o_m_tdata[31:ROW_W+COL_W] != want.pixel)
                        report_mismatch("pixel_out", want.pixel, o_m_tdata[31:ROW_W+COL_W]);
                    if (o_m_tlast != want.last)
                        report_mismatch("run_last", want.last, o_m_tlast);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic feed_pixel(input logic [PIX_W-1:0] value);
        pixel_queue.push_back(value);
        pixels_sent++;
    endtask

    task automatic feed_random(input int unsigned count);
        repeat (count) begin
            case ($urandom_range(7))
                0:       feed_pixel(8'd0);
                1:       feed_pixel(8'd255);
                default: feed_pixel(PIX_W'($urandom));
            endcase
        end
    endtask

    task automatic wait_drained();
        while (pixels_taken != pixels_sent || zoom_expected.size() != 0)
            @(negedge i_clk);
        // outside-window pixels leave no result to wait for
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADR_W-1:0] addr, input int unsigned value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= CFG_W'(value);
    endtask

    // Place a window on whole rows ahead of the counters. lead is the number of
    // pixels before the first window row, total covers the window to its end.
    task automatic set_window(input int unsigned columns, input int unsigned gap,
                              input int unsigned rows, input int unsigned first_col,
                              input int unsigned last_col, output int unsigned lead,
                              output int unsigned total);
        int unsigned span;
        int unsigned start;
        int unsigned skip;
        int unsigned first_row;
        wait_drained();
        span = (columns == 0) ? 1 : ((columns > DEF_MAX_COLS) ? DEF_MAX_COLS : columns);
        if (src_col == 0) begin
            start = src_row;
            skip  = 0;
        end else begin
            start = (src_row + 1) % DEF_MAX_ROWS;
            skip  = (src_col + 1 >= span) ? 1 : span - src_col;
        end
        first_row = start + gap;
        lead      = skip + gap * span;
        total     = lead + ((rows == 0) ? 1 : rows) * span;
        write_reg(CFG_IMAGE_COLUMNS, columns);
        write_reg(CFG_WINDOW_FIRST_ROW, first_row);
        write_reg(CFG_WINDOW_FIRST_COL, first_col);
        write_reg(CFG_WINDOW_LAST_ROW, first_row + rows - 1);
        write_reg(CFG_WINDOW_LAST_COL, last_col);
        write_reg(CFG_SPARE, $urandom);
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        cfg_columns   = IMG_COL_W'(columns);
        cfg_first_row = WIN_ROW_W'(first_row);
        cfg_first_col = WIN_COL_W'(first_col);
        cfg_last_row  = WIN_ROW_W'(first_row + rows - 1);
        cfg_last_col  = WIN_COL_W'(last_col);
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned lead;
        int unsigned total;
        int unsigned cols;
        int unsigned first_col;
        int unsigned last_col;
        int unsigned rows;
        int unsigned window_count;
        window_count = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset window is the single top-left pixel
        feed_pixel(8'd200);
        feed_pixel(8'd77);

        // image_columns of zero wraps every pixel, like one column
        set_window(0, 0, 2, 0, 0, lead, total);
        feed_random(lead);
        feed_pixel(8'd0);
        feed_pixel(8'd255);

        // full 3x3 window with saturating and rounding neighbors
        set_window(3, 0, 3, 0, 2, lead, total);
        feed_random(lead);
        feed_pixel(8'd255); feed_pixel(8'd255); feed_pixel(8'd0);
        feed_pixel(8'd0);   feed_pixel(8'd255); feed_pixel(8'd1);
        feed_pixel(8'd254); feed_pixel(8'd0);   feed_pixel(8'd255);

        // inverted rows, then inverted columns: nothing comes out
        set_window(4, 1, 0, 0, 3, lead, total);
        feed_random(total);
        set_window(4, 0, 2, 3, 1, lead, total);
        feed_random(total);

        // window reaching past the right edge of the image
        set_window(3, 0, 2, 1, 5, lead, total);
        feed_random(total);

        while (pixels_sent < INPUT_ITEMS) begin
            if (pixels_sent < INPUT_ITEMS / 3)
                pace = PACE_SLOW_SINK;
            else if (pixels_sent < 2 * INPUT_ITEMS / 3)
                pace = PACE_SLOW_SOURCE;
            else
                pace = PACE_FULL_RATE;
            if (window_count == 0) begin
                // large first window keeps requests coming through the hold-off
                cols      = 12;
                rows      = 6;
                first_col = 0;
                last_col  = 11;
                set_window(cols, 0, rows, first_col, last_col, lead, total);
            end else begin
                cols      = $urandom_range(12, 2);
                rows      = $urandom_range(6, 1);
                first_col = ($urandom_range(9) == 0) ? cols + 1 : $urandom_range(cols - 1, 0);
                last_col  = first_col + $urandom_range(cols, 0);
                set_window(cols, $urandom_range(2, 0), rows, first_col, last_col, lead, total);
            end
            feed_random(total);
            window_count++;
        end

        wait_drained();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
